@@ design/rtc_pkg.sv @@
// Shared types, step codes and constants of the RAMSETE tracking controller.
package rtc_pkg;

  // Sequencer steps; the datapath acts on the current step code.
  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_MRX   = 6'd1;
  localparam logic [5:0] S_RX    = 6'd2;
  localparam logic [5:0] S_RY    = 6'd3;
  localparam logic [5:0] S_TEST  = 6'd4;
  localparam logic [5:0] S_DXY   = 6'd5;
  localparam logic [5:0] S_EWRAP = 6'd6;
  localparam logic [5:0] S_COR1  = 6'd7;
  localparam logic [5:0] S_WAIT1 = 6'd8;
  localparam logic [5:0] S_M1    = 6'd9;
  localparam logic [5:0] S_M2    = 6'd10;
  localparam logic [5:0] S_M3    = 6'd11;
  localparam logic [5:0] S_M4    = 6'd12;
  localparam logic [5:0] S_M5    = 6'd13;
  localparam logic [5:0] S_M6    = 6'd14;
  localparam logic [5:0] S_M7    = 6'd15;
  localparam logic [5:0] S_M8    = 6'd16;
  localparam logic [5:0] S_SQRT  = 6'd17;
  localparam logic [5:0] S_WAIT2 = 6'd18;
  localparam logic [5:0] S_DIV   = 6'd19;
  localparam logic [5:0] S_WAIT3 = 6'd20;
  localparam logic [5:0] S_M10   = 6'd21;
  localparam logic [5:0] S_M11   = 6'd22;
  localparam logic [5:0] S_M12   = 6'd23;
  localparam logic [5:0] S_M13   = 6'd24;
  localparam logic [5:0] S_M14   = 6'd25;
  localparam logic [5:0] S_M15   = 6'd26;
  localparam logic [5:0] S_M16   = 6'd27;
  localparam logic [5:0] S_M17   = 6'd28;
  localparam logic [5:0] S_SUM   = 6'd29;
  localparam logic [5:0] S_M18   = 6'd30;
  localparam logic [5:0] S_M19   = 6'd31;
  localparam logic [5:0] S_M20   = 6'd32;
  localparam logic [5:0] S_FIN   = 6'd33;

  // Configuration register indexes
  localparam logic [2:0] CFG_DRIVE_FORWARD = 3'd0;
  localparam logic [2:0] CFG_FINAL_X       = 3'd1;
  localparam logic [2:0] CFG_FINAL_Y       = 3'd2;
  localparam logic [2:0] CFG_FINAL_YAW     = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd4;

  // Motion status codes
  localparam logic [1:0] MS_RUNNING = 2'd0;
  localparam logic [1:0] MS_GOAL    = 2'd1;
  localparam logic [1:0] MS_TIMEOUT = 2'd2;

  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [21:0] PI_Q16      = 22'sd205887;
  localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [21:0] TWO_PI_Q16  = 22'sd411775;
  localparam logic signed [18:0] CORDIC_START = 19'sd39797;
  localparam logic signed [31:0] INCH_TO_M = 32'sd426141;
  localparam logic signed [31:0] GAIN_1P4  = 32'sd91750;
  localparam logic signed [31:0] RPM_SCALE = 32'sd20695579;
  localparam logic signed [28:0] DONE_POS  = 29'sd1311;
  localparam logic signed [16:0] DONE_ANG  = 17'sd410;
  localparam logic signed [47:0] SUM_LIM   = 48'sd16777216;

  localparam logic signed [21:0] ATAN_TAB [16] = '{
    22'sd51472, 22'sd30386, 22'sd16055, 22'sd8150, 22'sd4091, 22'sd2047,
    22'sd1024, 22'sd512, 22'sd256, 22'sd128, 22'sd64, 22'sd32, 22'sd16,
    22'sd8, 22'sd4, 22'sd2
  };

  typedef struct packed {
    logic signed [22:0] ref_curvature;
    logic signed [19:0] ref_speed;
    logic signed [15:0] ref_yaw;
    logic signed [23:0] ref_y;
    logic signed [23:0] ref_x;
    logic signed [15:0] robot_heading;
    logic signed [23:0] robot_y;
    logic signed [23:0] robot_x;
  } in_item_t;

  typedef struct packed {
    logic [5:0] step;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic goal;
    logic timeout;
    logic e_ok;
    logic cor_busy;
    logic sq_busy;
    logic dv_busy;
    logic out_free;
  } stat_t;

endpackage

@@ design/rtc_cordic.sv @@
// Iterative CORDIC unit: range reduction then 16 rotation steps, Q16 sin and cos.
module rtc_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [21:0] angle_i,
  output logic               busy_o,
  output logic signed [18:0] sin_o,
  output logic signed [18:0] cos_o
);
  import rtc_pkg::*;

  localparam logic [1:0] C_IDLE   = 2'd0;
  localparam logic [1:0] C_REDUCE = 2'd1;
  localparam logic [1:0] C_ITER   = 2'd2;

  logic [1:0]         ph_q, ph_d;
  logic [3:0]         cnt_q, cnt_d;
  logic signed [21:0] a_q;
  logic signed [18:0] x_q, y_q;
  logic               neg_q;
  logic signed [18:0] dx, dy;

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;

  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    unique case (ph_q)
      C_IDLE: begin
        if (start_i) ph_d = C_REDUCE;
      end
      C_REDUCE: begin
        if (a_q <= PI_Q16 && a_q >= -PI_Q16) begin
          ph_d  = C_ITER;
          cnt_d = '0;
        end
      end
      C_ITER: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) ph_d = C_IDLE;
      end
      default: ph_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= C_IDLE;
      cnt_q <= '0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == C_IDLE && start_i) begin
      a_q   <= angle_i;
      neg_q <= 1'b0;
    end else if (ph_q == C_REDUCE) begin
      // wrap into +-pi, then fold into +-pi/2
      if (a_q > PI_Q16) begin
        a_q <= a_q - TWO_PI_Q16;
      end else if (a_q < -PI_Q16) begin
        a_q <= a_q + TWO_PI_Q16;
      end else begin
        x_q <= CORDIC_START;
        y_q <= '0;
        if (a_q > HALF_PI_Q16) begin
          a_q   <= a_q - PI_Q16;
          neg_q <= 1'b1;
        end else if (a_q < -HALF_PI_Q16) begin
          a_q   <= a_q + PI_Q16;
          neg_q <= 1'b1;
        end
      end
    end else if (ph_q == C_ITER) begin
      if (a_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        a_q <= a_q - ATAN_TAB[cnt_q];
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        a_q <= a_q + ATAN_TAB[cnt_q];
      end
    end
  end

  assign busy_o = (ph_q != C_IDLE);
  assign sin_o  = neg_q ? -y_q : y_q;
  assign cos_o  = neg_q ? -x_q : x_q;

endmodule

@@ design/rtc_ctrl.sv @@
// Sequencer state machine of the tracking controller.
module rtc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rtc_pkg::stat_t stat_i,
  output rtc_pkg::cmd_t  cmd_o
);
  import rtc_pkg::*;

  logic [5:0] state_q, state_d;

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = in_valid_i ? S_MRX : S_IDLE;
      S_TEST:  state_d = (stat_i.goal || stat_i.timeout) ? S_FIN : S_DXY;
      S_EWRAP: state_d = stat_i.e_ok ? S_COR1 : S_EWRAP;
      S_WAIT1: state_d = stat_i.cor_busy ? S_WAIT1 : S_M1;
      S_WAIT2: state_d = stat_i.cor_busy ? S_WAIT2 : S_DIV;
      S_WAIT3: state_d = (stat_i.dv_busy || stat_i.sq_busy) ? S_WAIT3 : S_M10;
      S_FIN:   state_d = stat_i.out_free ? S_IDLE : S_FIN;
      default: state_d = (state_q < S_FIN) ? state_q + 6'd1 : S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.step = state_q;
  assign cmd_o.load = (state_q == S_IDLE) && in_valid_i;

endmodule

@@ design/rtc_dp.sv @@
// Datapath: shared multiplier, iterative sqrt and divider, CORDIC, output register.
module rtc_dp #(
  parameter int TICK_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtc_pkg::cmd_t      cmd_i,
  output rtc_pkg::stat_t     stat_o,
  input  rtc_pkg::in_item_t  item_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [15:0] left_rpm_o,
  output logic signed [15:0] right_rpm_o,
  output logic [1:0]         motion_status_o
);
  import rtc_pkg::*;

  localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    rnd16 = (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] rnd32(input logic signed [63:0] v);
    rnd32 = (v + 64'sd2147483648) >>> 32;
  endfunction

  function automatic logic signed [25:0] clamp_sum(input logic signed [47:0] v);
    if (v > SUM_LIM) clamp_sum = 26'(SUM_LIM);
    else if (v < -SUM_LIM) clamp_sum = 26'(-SUM_LIM);
    else clamp_sum = 26'(v);
  endfunction

  function automatic logic signed [15:0] sat_rpm(input logic signed [63:0] v);
    if (v > 64'sd32767) sat_rpm = 16'sh7fff;
    else if (v < -64'sd32768) sat_rpm = 16'sh8000;
    else sat_rpm = 16'(v);
  endfunction

  // configuration
  logic               fwd_q;
  logic signed [23:0] fx_q, fy_q;
  logic signed [15:0] fyaw_q;
  logic [15:0]        tmo_q;
  logic [TICK_BITS-1:0] tick_q;

  // item and intermediates
  in_item_t           it_q;
  logic signed [63:0] p_q, acc_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [27:0] rx_q, ry_q;
  logic signed [17:0] th_q, e13_q;
  logic signed [28:0] dx_q, dy_q;
  logic signed [18:0] st_q, ct_q, se_q, ce_q;
  logic signed [31:0] ex_q, ey_q;
  logic signed [26:0] wd_q;
  logic signed [27:0] k_q;
  logic signed [25:0] t_q;
  logic signed [47:0] v_q, w_q;
  logic signed [25:0] ls_q, rs_q;
  logic signed [15:0] lrpm_q, rrpm_q;
  logic [1:0]         status_q;

  logic               out_valid_q;
  logic signed [15:0] out_l_q, out_r_q;
  logic [1:0]         out_st_q;

  // goal and timeout tests
  logic signed [28:0] gdx, gdy;
  logic signed [16:0] gda;
  logic               goal, timeout;
  logic signed [17:0] th_flip;
  logic signed [20:0] th16, e16;

  assign gdx = 29'(rx_q) - 29'(fx_q);
  assign gdy = 29'(ry_q) - 29'(fy_q);
  assign gda = 17'(it_q.robot_heading) - 17'(fyaw_q);
  assign goal = gdx > -DONE_POS && gdx < DONE_POS && gdy > -DONE_POS && gdy < DONE_POS &&
                gda > -DONE_ANG && gda < DONE_ANG;
  assign timeout = CW'(tick_q) >= CW'(tmo_q);

  always_comb begin
    th_flip = 18'(it_q.robot_heading);
    if (!fwd_q) begin
      th_flip = th_flip + PI_Q13;
      if (th_flip > PI_Q13) th_flip = th_flip - TWO_PI_Q13;
      if (th_flip < -PI_Q13) th_flip = th_flip + TWO_PI_Q13;
    end
  end

  assign th16 = $signed({th_q, 3'b000});
  assign e16  = $signed({e13_q, 3'b000});

  // CORDIC
  logic               cor_start, cor_busy;
  logic signed [21:0] cor_angle;
  logic signed [18:0] cor_sin, cor_cos;

  assign cor_start = (cmd_i.step == S_COR1) || (cmd_i.step == S_M5);
  assign cor_angle = (cmd_i.step == S_COR1) ? 22'(th16) : 22'(e16);

  rtc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .busy_o  (cor_busy),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  // square root, one result bit per cycle
  logic        sq_busy_q;
  logic [4:0]  sq_cnt_q;
  logic [51:0] sq_rad_q;
  logic [29:0] sq_rem_q, sq_r2, sq_trial;
  logic [25:0] sq_root_q;
  logic        sq_ge;

  assign sq_r2    = {sq_rem_q[27:0], sq_rad_q[51:50]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_r2 >= sq_trial;

  // restoring divider for sinc, one quotient bit per cycle
  logic        dv_busy_q;
  logic [5:0]  dv_cnt_q;
  logic [34:0] dv_num_q;
  logic [19:0] dv_rem_q, dv_den_q;
  logic        dv_neg_q;
  logic [20:0] dv_tmp;
  logic        dv_ge;
  logic [18:0] sin_abs;
  logic [19:0] e_abs;
  logic signed [20:0] sinc;

  assign dv_tmp  = {dv_rem_q, dv_num_q[34]};
  assign dv_ge   = dv_tmp >= {1'b0, dv_den_q};
  assign sin_abs = cor_sin[18] ? 19'(-cor_sin) : 19'(cor_sin);
  assign e_abs   = e16[20] ? 20'(-e16) : 20'(e16);
  assign sinc    = (e13_q == '0) ? 21'sd65536 :
                   (dv_neg_q ? -$signed(dv_num_q[20:0]) : $signed(dv_num_q[20:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
      dv_busy_q <= 1'b0;
      dv_cnt_q  <= '0;
    end else begin
      if (cmd_i.step == S_SQRT) begin
        sq_busy_q <= 1'b1;
        sq_cnt_q  <= '0;
      end else if (sq_busy_q) begin
        sq_cnt_q <= sq_cnt_q + 5'd1;
        if (sq_cnt_q == 5'd25) sq_busy_q <= 1'b0;
      end
      if (cmd_i.step == S_DIV && e13_q != '0) begin
        dv_busy_q <= 1'b1;
        dv_cnt_q  <= '0;
      end else if (dv_busy_q) begin
        dv_cnt_q <= dv_cnt_q + 6'd1;
        if (dv_cnt_q == 6'd34) dv_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == S_SQRT) begin
      sq_rad_q  <= 52'(acc_q + (p_q <<< 1));
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_busy_q) begin
      sq_rad_q  <= {sq_rad_q[49:0], 2'b00};
      sq_rem_q  <= sq_ge ? sq_r2 - sq_trial : sq_r2;
      sq_root_q <= {sq_root_q[24:0], sq_ge};
    end
    if (cmd_i.step == S_DIV) begin
      dv_num_q <= {sin_abs, 16'h0000};
      dv_rem_q <= '0;
      dv_den_q <= e_abs;
      dv_neg_q <= cor_sin[18] ^ e16[20];
    end else if (dv_busy_q) begin
      dv_rem_q <= dv_ge ? 20'(dv_tmp - {1'b0, dv_den_q}) : dv_tmp[19:0];
      dv_num_q <= {dv_num_q[33:0], dv_ge};
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      S_MRX: begin mul_a = 32'(it_q.robot_x); mul_b = INCH_TO_M; end
      S_RX:  begin mul_a = 32'(it_q.robot_y); mul_b = INCH_TO_M; end
      S_M1:  begin mul_a = 32'(cor_cos); mul_b = 32'(dx_q); end
      S_M2:  begin mul_a = 32'(st_q); mul_b = 32'(dy_q); end
      S_M3:  begin mul_a = 32'(ct_q); mul_b = 32'(dy_q); end
      S_M4:  begin mul_a = 32'(st_q); mul_b = 32'(dx_q); end
      S_M5:  begin mul_a = 32'(it_q.ref_speed); mul_b = 32'(it_q.ref_curvature); end
      S_M7:  begin mul_a = 32'(wd_q); mul_b = 32'(wd_q); end
      S_M8:  begin mul_a = 32'(it_q.ref_speed); mul_b = 32'(it_q.ref_speed); end
      S_M10: begin mul_a = $signed({6'b000000, sq_root_q}); mul_b = GAIN_1P4; end
      S_M11: begin mul_a = 32'(it_q.ref_speed); mul_b = 32'(ce_q); end
      S_M12: begin mul_a = 32'(k_q); mul_b = ex_q; end
      S_M13: begin mul_a = 32'(it_q.ref_speed); mul_b = 32'(sinc); end
      S_M14: begin mul_a = 32'(k_q); mul_b = 32'(e16); end
      S_M16: begin mul_a = 32'(t_q); mul_b = ey_q; end
      S_M18: begin mul_a = 32'(ls_q); mul_b = RPM_SCALE; end
      S_M19: begin mul_a = 32'(rs_q); mul_b = RPM_SCALE; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (cmd_i.load) it_q <= item_i;
    unique case (cmd_i.step)
      S_RX: rx_q <= 28'(rnd16(p_q));
      S_RY: ry_q <= 28'(rnd16(p_q));
      S_TEST: begin
        th_q     <= th_flip;
        status_q <= goal ? MS_GOAL : (timeout ? MS_TIMEOUT : MS_RUNNING);
      end
      S_DXY: begin
        dx_q  <= 29'(it_q.ref_x) - 29'(rx_q);
        dy_q  <= 29'(it_q.ref_y) - 29'(ry_q);
        e13_q <= 18'(it_q.ref_yaw) - th_q;
      end
      S_EWRAP: begin
        if (e13_q > PI_Q13) e13_q <= e13_q - TWO_PI_Q13;
        else if (e13_q < -PI_Q13) e13_q <= e13_q + TWO_PI_Q13;
      end
      S_M1: begin
        st_q <= cor_sin;
        ct_q <= cor_cos;
      end
      S_M2:  acc_q <= p_q;
      S_M3:  ex_q <= 32'(rnd16(acc_q + p_q));
      S_M4:  acc_q <= p_q;
      S_M5:  ey_q <= 32'(rnd16(acc_q - p_q));
      S_M6:  wd_q <= 27'(rnd16(p_q));
      S_M8:  acc_q <= p_q;
      S_DIV: begin
        se_q <= cor_sin;
        ce_q <= cor_cos;
      end
      S_M11: k_q <= 28'(rnd16(p_q));
      S_M12: v_q <= 48'(rnd16(p_q));
      S_M13: v_q <= v_q + 48'(rnd16(p_q));
      S_M14: t_q <= 26'(rnd16(p_q) * 64'sd5);
      S_M15: w_q <= 48'(wd_q) + 48'(rnd16(p_q));
      S_M17: w_q <= w_q + 48'(rnd16(p_q));
      S_SUM: begin
        ls_q <= clamp_sum(fwd_q ? v_q + w_q : w_q - v_q);
        rs_q <= clamp_sum(fwd_q ? v_q - w_q : -v_q - w_q);
      end
      S_M19: lrpm_q <= sat_rpm(rnd32(p_q));
      S_M20: rrpm_q <= sat_rpm(rnd32(p_q));
      default: begin end
    endcase
  end

  // output register; a waiting result holds the sequencer in S_FIN and so blocks the next transfer in
  logic fin_load;
  assign fin_load = (cmd_i.step == S_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tick_q      <= '0;
      fwd_q       <= 1'b1;
      fx_q        <= '0;
      fy_q        <= '0;
      fyaw_q      <= '0;
      tmo_q       <= 16'hffff;
    end else begin
      if (fin_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (fin_load && status_q == MS_RUNNING && tick_q != '1) begin
        tick_q <= tick_q + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DRIVE_FORWARD: fwd_q  <= cfg_data_i[0];
          CFG_FINAL_X:       fx_q   <= cfg_data_i;
          CFG_FINAL_Y:       fy_q   <= cfg_data_i;
          CFG_FINAL_YAW:     fyaw_q <= cfg_data_i[15:0];
          CFG_TIMEOUT_TICKS: tmo_q  <= cfg_data_i[15:0];
          default: begin end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_st_q <= status_q;
      out_l_q  <= (status_q == MS_RUNNING) ? lrpm_q : '0;
      out_r_q  <= (status_q == MS_RUNNING) ? rrpm_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_rpm_o      = out_l_q;
  assign right_rpm_o     = out_r_q;
  assign motion_status_o = out_st_q;

  assign stat_o.goal     = goal;
  assign stat_o.timeout  = timeout;
  assign stat_o.e_ok     = (e13_q <= PI_Q13) && (e13_q >= -PI_Q13);
  assign stat_o.cor_busy = cor_busy;
  assign stat_o.sq_busy  = sq_busy_q;
  assign stat_o.dv_busy  = dv_busy_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

@@ design/ramsete_tracking_controller.sv @@
// A running tick goes through every step; goal or timeout sends S_TEST straight to S_FIN.
// Throughput: one tick at a time; the next input transfer is taken when the sequencer idles.
// The running path is set by the 35-step sinc divider, two CORDIC passes and the steps
// through the one shared 32x32 multiplier; sqrt overlaps the CORDIC.
// Reset is asynchronous, active low: control and config registers reset, tick count clears.
module ramsete_tracking_controller #(
  parameter int TICK_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // robot_x, robot_y, robot_heading, ref_x, ref_y, ref_yaw, ref_speed, ref_curvature
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_rpm, right_rpm
  output logic [31:0]  m_axis_tdata,
  // motion_status
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);
  import rtc_pkg::*;

  cmd_t     cmd;
  stat_t    stat;
  in_item_t item;
  logic signed [15:0] left_rpm, right_rpm;

  assign item.robot_x       = s_axis_tdata[23:0];
  assign item.robot_y       = s_axis_tdata[47:24];
  assign item.robot_heading = s_axis_tdata[63:48];
  assign item.ref_x         = s_axis_tdata[87:64];
  assign item.ref_y         = s_axis_tdata[111:88];
  assign item.ref_yaw       = s_axis_tdata[127:112];
  assign item.ref_speed     = s_axis_tdata[147:128];
  assign item.ref_curvature = s_axis_tdata[170:148];

  rtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rtc_dp #(
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .item_i          (item),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .left_rpm_o      (left_rpm),
    .right_rpm_o     (right_rpm),
    .motion_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {right_rpm, left_rpm};

endmodule

@@ bench/ramsete_tracking_controller_test.sv @@
// Self-checking bench of the RAMSETE tracking controller: directed table, then random ticks.
`timescale 1ns / 100ps

module ramsete_tracking_controller_test;
  import rtc_pkg::*;

  typedef struct packed {
    logic signed [15:0] left_rpm;
    logic signed [15:0] right_rpm;
    logic [1:0]         status;
  } wheel_cmd_t;

  typedef struct {
    logic       fwd;
    logic [15:0] tmo;
    in_item_t   item;
    bit         typed;
    wheel_cmd_t cmd;
  } tick_row_t;

  localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint TICK_MAX = 65535;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [23:0]  cfg_data_i;

  // Shadow registers and tick counter of the predictor
  logic         sh_forward;
  logic [23:0]  sh_final_x;
  logic [23:0]  sh_final_y;
  logic [15:0]  sh_final_yaw;
  logic [15:0]  sh_timeout;
  longint       sh_ticks;

  wheel_cmd_t   cmd_q[$];
  tick_row_t    rows[$];
  int           err_cnt;
  int           result_cnt;
  int           goal_cnt;
  int           tmo_cnt;
  bit           no_idle;
  bit           hold_req;

  ramsete_tracking_controller #(.TICK_BITS(16)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // CORDIC rotation, angle and results in Q16
  function automatic void cordic_sincos(longint a, output longint s, output longint c);
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    x    = 39797;
    y    = 0;
    flip = 0;
    while (a > 205887) a = a - 411775;
    while (a < -205887) a = a + 411775;
    if (a > 102944) begin
      a    = a - 205887;
      flip = 1;
    end else if (a < -102944) begin
      a    = a + 205887;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x = x - dx;
        y = y + dy;
        a = a - ATAN_Q16[i];
      end else begin
        x = x + dx;
        y = y - dy;
        a = a + ATAN_Q16[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [15:0] sum_to_rpm(longint sum);
    longint r;
    if (sum > 16777216) sum = 16777216;
    if (sum < -16777216) sum = -16777216;
    r = round_shift(sum * 20695579, 32);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // One control tick: wheel commands and status; advances the tick counter on a running tick
  function automatic wheel_cmd_t track_tick(in_item_t it);
    wheel_cmd_t res;
    longint rx, ry, hd, th, dx, dy, st, ct, ex, ey, e, se, ce;
    longint vd, cv, wd, k, v, w, sinc, t, lsum, rsum;
    longint unsigned q;
    rx = round_shift(longint'(it.robot_x) * 426141, 16);
    ry = round_shift(longint'(it.robot_y) * 426141, 16);
    hd = it.robot_heading;
    vd = it.ref_speed;
    cv = it.ref_curvature;
    res = '0;
    if (abs64(rx - longint'($signed(sh_final_x))) < 1311 &&
        abs64(ry - longint'($signed(sh_final_y))) < 1311 &&
        abs64(hd - longint'($signed(sh_final_yaw))) < 410) begin
      res.status = MS_GOAL;
      return res;
    end
    if (sh_ticks >= longint'(sh_timeout)) begin
      res.status = MS_TIMEOUT;
      return res;
    end
    th = hd;
    if (!sh_forward) begin
      th = th + 25736;
      if (th > 25736) th = th - 51472;
      if (th < -25736) th = th + 51472;
    end
    dx = longint'(it.ref_x) - rx;
    dy = longint'(it.ref_y) - ry;
    cordic_sincos(th * 8, st, ct);
    ex = round_shift(ct * dx + st * dy, 16);
    ey = round_shift(ct * dy - st * dx, 16);
    e = longint'(it.ref_yaw) - th;
    while (e > 25736) e = e - 51472;
    while (e < -25736) e = e + 51472;
    e = e * 8;
    cordic_sincos(e, se, ce);
    wd = round_shift(vd * cv, 16);
    q  = longint'(wd * wd) + 2 * longint'(vd * vd);
    k  = round_shift(floor_sqrt(q) * 91750, 16);
    v  = round_shift(vd * ce, 16) + round_shift(k * ex, 16);
    sinc = (e == 0) ? 65536 : (se * 65536) / e;
    t  = round_shift(vd * sinc, 16) * 5;
    w  = wd + round_shift(k * e, 16) + round_shift(t * ey, 16);
    if (sh_forward) begin
      lsum = v + w;
      rsum = v - w;
    end else begin
      lsum = -v + w;
      rsum = -v - w;
    end
    res.left_rpm  = sum_to_rpm(lsum);
    res.right_rpm = sum_to_rpm(rsum);
    res.status    = MS_RUNNING;
    if (sh_ticks < TICK_MAX) sh_ticks++;
    return res;
  endfunction

  function automatic in_item_t pose_ref(longint rx, longint ry, longint hd, longint gx,
                                        longint gy, longint gyaw, longint vd, longint cv);
    in_item_t it;
    it.robot_x       = rx[23:0];
    it.robot_y       = ry[23:0];
    it.robot_heading = hd[15:0];
    it.ref_x         = gx[23:0];
    it.ref_y         = gy[23:0];
    it.ref_yaw       = gyaw[15:0];
    it.ref_speed     = vd[19:0];
    it.ref_curvature = cv[22:0];
    return it;
  endfunction

  function automatic longint rand_angle();
    return longint'($urandom_range(0, 51472)) - 25736;
  endfunction

  function automatic longint clamp_angle(longint a);
    return (a > 25736) ? 25736 : ((a < -25736) ? -25736 : a);
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t it;
    int sel;
    it  = $urandom;
    it  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    sel = $urandom_range(0, 7);
    it.robot_heading = rand_angle();
    it.ref_yaw       = rand_angle();
    if (sel < 3) begin
      // land the pose near the goal, within or just outside the window
      it.robot_x = (longint'($signed(sh_final_x)) * 65536) / 426141 +
                   $urandom_range(0, 440) - 220;
      it.robot_y = (longint'($signed(sh_final_y)) * 65536) / 426141 +
                   $urandom_range(0, 440) - 220;
      it.robot_heading = clamp_angle(longint'($signed(sh_final_yaw)) +
                                     $urandom_range(0, 900) - 450);
    end else if (sel < 6) begin
      // moderate tracking errors and speeds
      it.robot_x       = longint'($urandom_range(0, 20000)) - 10000;
      it.robot_y       = longint'($urandom_range(0, 20000)) - 10000;
      it.ref_x         = longint'($urandom_range(0, 120000)) - 60000;
      it.ref_y         = longint'($urandom_range(0, 120000)) - 60000;
      it.ref_speed     = longint'($urandom_range(0, 200000)) - 100000;
      it.ref_curvature = longint'($urandom_range(0, 300000)) - 150000;
    end
    if ($urandom_range(0, 7) == 0) it.ref_yaw = it.robot_heading;
    return it;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_DRIVE_FORWARD: sh_forward   = val[0];
      CFG_FINAL_X:       sh_final_x   = val;
      CFG_FINAL_Y:       sh_final_y   = val;
      CFG_FINAL_YAW:     sh_final_yaw = val[15:0];
      CFG_TIMEOUT_TICKS: sh_timeout   = val[15:0];
      default: ;
    endcase
  endtask

  // Offer one tick from a falling edge; returns at the falling edge after the transfer
  task automatic send_tick(in_item_t it, bit typed, wheel_cmd_t typed_cmd);
    int gap;
    wheel_cmd_t pred;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= it;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = track_tick(it);
    cmd_q.push_back(typed ? typed_cmd : pred);
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    wheel_cmd_t none;
    none = '0;
    for (int i = 0; i < n; i++) send_tick(rand_tick(), 1'b0, none);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    int gap;
    wheel_cmd_t got;
    wheel_cmd_t want;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < 1500; c++) @(negedge clk_i);
        hold_req = 0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.left_rpm  = m_axis_tdata[15:0];
      got.right_rpm = m_axis_tdata[31:16];
      got.status    = m_axis_tuser;
      result_cnt++;
      if (got.status == MS_GOAL) goal_cnt++;
      if (got.status == MS_TIMEOUT) tmo_cnt++;
      if (cmd_q.size() == 0) begin
        $error("result transfer with nothing expected");
        err_cnt++;
      end else begin
        want = cmd_q.pop_front();
        if (got.left_rpm !== want.left_rpm) begin
          $error("left_rpm: expected %0d, got %0d", want.left_rpm, got.left_rpm);
          err_cnt++;
        end
        if (got.right_rpm !== want.right_rpm) begin
          $error("right_rpm: expected %0d, got %0d", want.right_rpm, got.right_rpm);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $error("motion_status: expected %0d, got %0d", want.status, got.status);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    wheel_cmd_t goal_cmd;
    wheel_cmd_t tmo_cmd;
    wheel_cmd_t none;
    tick_row_t  row;
    int         lim;
    goal_cmd = '{left_rpm: 16'sd0, right_rpm: 16'sd0, status: MS_GOAL};
    tmo_cmd  = '{left_rpm: 16'sd0, right_rpm: 16'sd0, status: MS_TIMEOUT};
    none     = '0;
    err_cnt = 0; result_cnt = 0; goal_cnt = 0; tmo_cnt = 0;
    no_idle = 0; hold_req = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DRIVE_FORWARD;
    cfg_data_i    = '0;
    sh_forward = 1'b1; sh_final_x = '0; sh_final_y = '0; sh_final_yaw = '0;
    sh_timeout = 16'hFFFF; sh_ticks = 0;

    // Directed ticks at the reset goal of the origin
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, goal_cmd});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(200, -200, 409, 5, 5, 5, 5, 5), 1'b1,
                     goal_cmd});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(200, -200, 410, 0, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(202, 0, 0, 0, 0, 0, 65536, 0), 1'b0, none});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(8388607, 8388607, 25736, 8388607, 8388607,
                     25736, 524287, 4194303), 1'b0, none});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(-8388608, -8388608, -25736, -8388608,
                     -8388608, -25736, -524288, -4194304), 1'b0, none});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(8388607, -8388608, 0, -8388608, 8388607,
                     0, 524287, -4194304), 1'b0, none});
    // zero heading error: sinc taken as one
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(3000, -1000, 1000, 50000, 20000, 1000,
                     65536, 0), 1'b0, none});
    // heading error wraps around pi
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(-4000, 2500, -25000, 10000, -30000, 25000,
                     40000, 30000), 1'b0, none});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(10000, 10000, 5000, 0, 0, -5000, 0, 0),
                     1'b0, none});
    rows.push_back('{1'b1, 16'hFFFF, pose_ref(-6000, 7000, 12000, 90000, -80000, -12000,
                     -300000, 2000000), 1'b0, none});
    // reverse: flipped heading wraps past pi
    rows.push_back('{1'b0, 16'hFFFF, pose_ref(5000, 5000, 25736, 40000, 40000, 0, 65536,
                     65536), 1'b0, none});
    rows.push_back('{1'b0, 16'hFFFF, pose_ref(5000, -5000, -25736, -40000, 40000, 20000,
                     -65536, -65536), 1'b0, none});
    rows.push_back('{1'b0, 16'hFFFF, pose_ref(0, 0, 300, 7, 7, 7, 7, 7), 1'b1, goal_cmd});
    rows.push_back('{1'b0, 16'hFFFF, pose_ref(-1000, 800, 0, 60000, 60000, -3000, 524287,
                     -4194304), 1'b0, none});
    // zero timeout: goal still wins, otherwise timed out
    rows.push_back('{1'b1, 16'h0000, pose_ref(1000, 1000, 100, 0, 0, 0, 0, 0), 1'b1,
                     tmo_cmd});
    rows.push_back('{1'b1, 16'h0000, pose_ref(0, 0, -409, 0, 0, 0, 65536, 0), 1'b1,
                     goal_cmd});
    rows.push_back('{1'b1, 16'h0000, pose_ref(8388607, 0, 0, 0, 0, 0, 524287, 0), 1'b1,
                     tmo_cmd});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.fwd != sh_forward || row.tmo != sh_timeout) begin
        s_axis_tvalid <= 1'b0;
        if (row.fwd != sh_forward) write_reg(CFG_DRIVE_FORWARD, {23'd0, row.fwd});
        if (row.tmo != sh_timeout) write_reg(CFG_TIMEOUT_TICKS, {8'd0, row.tmo});
      end
      send_tick(row.item, row.typed, row.cmd);
    end
    s_axis_tvalid <= 1'b0;

    write_reg(CFG_DRIVE_FORWARD, 24'd1);
    write_reg(CFG_TIMEOUT_TICKS, 24'hFFFF);
    send_random(90);

    write_reg(CFG_DRIVE_FORWARD, 24'd0);
    write_reg(CFG_FINAL_X, 24'h7FFFFF);
    write_reg(CFG_FINAL_Y, 24'h800000);
    write_reg(CFG_FINAL_YAW, 24'd25736);
    send_random(70);

    write_reg(CFG_TIMEOUT_TICKS, 24'd0);
    write_reg(CFG_FINAL_X, 24'h800000);
    write_reg(CFG_FINAL_Y, 24'h7FFFFF);
    write_reg(CFG_FINAL_YAW, 24'hFF9B78);
    no_idle = 1;
    send_random(40);
    no_idle = 0;

    // timeout reached partway through this phase
    lim = sh_ticks + 30;
    write_reg(CFG_DRIVE_FORWARD, 24'd1);
    write_reg(CFG_TIMEOUT_TICKS, lim[23:0]);
    write_reg(CFG_FINAL_X, {$urandom} % 24'h100000);
    write_reg(CFG_FINAL_YAW, longint'(rand_angle()) & 24'hFFFF);
    send_random(90);

    write_reg(CFG_TIMEOUT_TICKS, 24'hFFFF);
    write_reg(CFG_DRIVE_FORWARD, 24'd0);
    write_reg(CFG_FINAL_Y, $urandom);
    hold_req = 1;
    send_random(90);

    wait_idle();
    $display("Covered %0d ticks: %0d goal reached, %0d timed out, both drive directions,",
             result_cnt, goal_cnt, tmo_cnt);
    $display("goal and timeout register extremes, random stalls and one long output stall.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
